// ===== rtl/core/stream_debug_tap_controller_macros.svh =====
// Assertion macros used by the stream debug tap core.
`ifndef STREAM_DEBUG_TAP_CONTROLLER_MACROS_SVH
`define STREAM_DEBUG_TAP_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SDTC_ASSERT_NOW(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
		else $error("sdtc assertion failed");

// Next-cycle implication, checked out of reset.
`define SDTC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
		else $error("sdtc assertion failed");

`endif

// ===== rtl/core/sdtc_pkg.sv =====
`default_nettype none
package sdtc_pkg;

	// Data path and counter widths.
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 10;
	localparam int ADDR_W   = 4;
	localparam int REG_W    = 4;
	localparam int STATUS_W = 8;
	localparam int FWD_ADDR_W = ADDR_W + REG_W;

	// Packed stream widths, padded to whole bytes.
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 112;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FORWARD_ENABLE = 2'd1;

	// Command register numbers.
	localparam logic [REG_W-1:0] REG_DROP_COUNT = 4'd0;
	localparam logic [REG_W-1:0] REG_LOG_COUNT  = 4'd1;
	localparam logic [REG_W-1:0] REG_INJ_WORD   = 4'd2;
	localparam logic [REG_W-1:0] REG_INJ_VALID  = 4'd3;
	localparam logic [REG_W-1:0] REG_PAUSE      = 4'd8;
	localparam logic [REG_W-1:0] REG_LOG        = 4'd9;
	localparam logic [REG_W-1:0] REG_DROP       = 4'd10;
	localparam logic [REG_W-1:0] REG_LATCH      = 4'd15;

	// Receipt header tag, or-ed with the own address.
	localparam logic [ADDR_W:0] RECEIPT_TAG = 5'b10000;

	// One cycle's worth of input.
	typedef struct packed {
		logic              out_ready;
		logic              log_rdy;
		logic              in_valid;
		logic [DATA_W-1:0] in_data;
		logic              cmd_valid;
		logic [ADDR_W-1:0] cmd_target;
		logic [REG_W-1:0]  cmd_reg;
		logic [DATA_W-1:0] cmd_value;
	} item_t;

	// One cycle's worth of result.
	typedef struct packed {
		logic                  out_valid;
		logic [DATA_W-1:0]     out_data;
		logic                  log_valid;
		logic [DATA_W-1:0]     log_word;
		logic                  log_last;
		logic                  in_accepted;
		logic                  fwd_valid;
		logic [FWD_ADDR_W-1:0] fwd_address;
		logic [DATA_W-1:0]     fwd_value;
		logic                  fwd_has_value;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/core/sdtc_core.sv =====
`default_nettype none
`include "stream_debug_tap_controller_macros.svh"
module sdtc_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire sdtc_pkg::item_t             item,
	input  wire logic [sdtc_pkg::ADDR_W-1:0] own_address,
	input  wire logic                        forward_enable,
	output sdtc_pkg::result_t                result
);

	// Live settings and inject.
	logic                          live_pause_q, live_log_q, live_drop_q;
	logic [sdtc_pkg::COUNT_W-1:0]  live_log_count_q, live_drop_count_q;
	logic                          inject_pending_q;
	logic [sdtc_pkg::DATA_W-1:0]   inject_word_q;
	// Scratch settings.
	logic                          scratch_pause_q, scratch_log_q, scratch_drop_q;
	logic [sdtc_pkg::COUNT_W-1:0]  scratch_log_count_q, scratch_drop_count_q;
	logic                          scratch_inject_valid_q;
	logic [sdtc_pkg::DATA_W-1:0]   scratch_inject_word_q;
	// Log sequencer and receipt.
	logic                          second_flit_pending_q, second_flit_is_receipt_q;
	logic [sdtc_pkg::DATA_W-1:0]   second_flit_word_q;
	logic                          receipt_pending_q;
	logic [sdtc_pkg::STATUS_W-1:0] receipt_status_q;

	// Next-state values.
	logic                          live_pause_d, live_log_d, live_drop_d;
	logic [sdtc_pkg::COUNT_W-1:0]  live_log_count_d, live_drop_count_d;
	logic                          inject_pending_d;
	logic [sdtc_pkg::DATA_W-1:0]   inject_word_d;
	logic                          scratch_pause_d, scratch_log_d, scratch_drop_d;
	logic [sdtc_pkg::COUNT_W-1:0]  scratch_log_count_d, scratch_drop_count_d;
	logic                          scratch_inject_valid_d;
	logic [sdtc_pkg::DATA_W-1:0]   scratch_inject_word_d;
	logic                          second_flit_pending_d, second_flit_is_receipt_d;
	logic [sdtc_pkg::DATA_W-1:0]   second_flit_word_d;
	logic                          receipt_pending_d;
	logic [sdtc_pkg::STATUS_W-1:0] receipt_status_d;

	logic out_free, log_free, to_log, to_out, inject_failed;

	// One cycle of the tap: output, log, stream, then command.
	always_comb begin
		live_pause_d             = live_pause_q;
		live_log_d               = live_log_q;
		live_drop_d              = live_drop_q;
		live_log_count_d         = live_log_count_q;
		live_drop_count_d        = live_drop_count_q;
		inject_pending_d         = inject_pending_q;
		inject_word_d            = inject_word_q;
		scratch_pause_d          = scratch_pause_q;
		scratch_log_d            = scratch_log_q;
		scratch_drop_d           = scratch_drop_q;
		scratch_log_count_d      = scratch_log_count_q;
		scratch_drop_count_d     = scratch_drop_count_q;
		scratch_inject_valid_d   = scratch_inject_valid_q;
		scratch_inject_word_d    = scratch_inject_word_q;
		second_flit_pending_d    = second_flit_pending_q;
		second_flit_is_receipt_d = second_flit_is_receipt_q;
		second_flit_word_d       = second_flit_word_q;
		receipt_pending_d        = receipt_pending_q;
		receipt_status_d         = receipt_status_q;
		result        = '0;
		out_free      = 1'b0;
		log_free      = 1'b0;
		to_log        = 1'b0;
		to_out        = 1'b0;
		inject_failed = 1'b0;

		// A pending inject word has first claim on the output.
		if (item.out_ready) begin
			if (inject_pending_q) begin
				result.out_valid = 1'b1;
				result.out_data  = inject_word_q;
				inject_pending_d = 1'b0;
			end else begin
				out_free = 1'b1;
			end
		end

		// Log channel: data flit first, then a waiting receipt header.
		if (item.log_rdy) begin
			if (second_flit_pending_q) begin
				result.log_valid      = 1'b1;
				result.log_word       = second_flit_word_q;
				result.log_last       = 1'b1;
				second_flit_pending_d = 1'b0;
				if (!second_flit_is_receipt_q && live_log_count_q != '0) begin
					live_log_count_d = live_log_count_q - 1'b1;
				end
			end else if (receipt_pending_q) begin
				result.log_valid = 1'b1;
				result.log_word  = {{(sdtc_pkg::DATA_W-sdtc_pkg::ADDR_W-1){1'b0}},
					sdtc_pkg::RECEIPT_TAG | {1'b0, own_address}};
				second_flit_word_d = {{(sdtc_pkg::DATA_W-sdtc_pkg::STATUS_W){1'b0}},
					receipt_status_q};
				second_flit_is_receipt_d = 1'b1;
				second_flit_pending_d    = 1'b1;
				receipt_pending_d        = 1'b0;
			end else begin
				log_free = 1'b1;
			end
		end

		// Stream word: gate, copy to the log, pass or drop.
		if (item.in_valid) begin
			to_log = (live_log_count_d != '0) || live_log_q;
			to_out = (live_log_count_d == '0) && !live_drop_q;
			if ((!to_out || out_free) && (!to_log || log_free) && !live_pause_q) begin
				result.in_accepted = 1'b1;
				if (to_out) begin
					result.out_valid = 1'b1;
					result.out_data  = item.in_data;
				end else if (live_drop_count_q != '0) begin
					live_drop_count_d = live_drop_count_q - 1'b1;
				end
				if (to_log) begin
					result.log_valid = 1'b1;
					result.log_word  = {{(sdtc_pkg::DATA_W-sdtc_pkg::ADDR_W){1'b0}},
						own_address};
					second_flit_word_d       = item.in_data;
					second_flit_is_receipt_d = 1'b0;
					second_flit_pending_d    = 1'b1;
				end
			end
		end

		// Command: forward, latch, or scratch write.
		if (item.cmd_valid) begin
			if (item.cmd_target != own_address) begin
				if (forward_enable) begin
					result.fwd_valid   = 1'b1;
					result.fwd_address = {item.cmd_target, item.cmd_reg};
					if (item.cmd_reg != sdtc_pkg::REG_LATCH) begin
						result.fwd_value     = item.cmd_value;
						result.fwd_has_value = 1'b1;
					end
				end
			end else if (item.cmd_reg == sdtc_pkg::REG_LATCH) begin
				inject_failed     = inject_pending_d;
				live_drop_d       = scratch_drop_q;
				live_drop_count_d = scratch_drop_count_q;
				live_log_d        = scratch_log_q;
				live_log_count_d  = scratch_log_count_q;
				live_pause_d      = scratch_pause_q;
				if (!inject_failed || !scratch_inject_valid_q) begin
					inject_pending_d = scratch_inject_valid_q;
					inject_word_d    = scratch_inject_word_q;
				end
				receipt_status_d = {inject_failed, 1'b0, scratch_inject_valid_q,
					scratch_drop_count_q != '0, scratch_log_count_q != '0,
					scratch_drop_q, scratch_log_q, scratch_pause_q};
				receipt_pending_d = 1'b1;
			end else begin
				unique case (item.cmd_reg)
					sdtc_pkg::REG_DROP_COUNT: begin
						scratch_drop_count_d = item.cmd_value[sdtc_pkg::COUNT_W-1:0];
					end
					sdtc_pkg::REG_LOG_COUNT: begin
						scratch_log_count_d = item.cmd_value[sdtc_pkg::COUNT_W-1:0];
					end
					sdtc_pkg::REG_INJ_WORD: begin
						scratch_inject_word_d = item.cmd_value;
					end
					sdtc_pkg::REG_INJ_VALID: begin
						scratch_inject_valid_d = item.cmd_value[0];
					end
					sdtc_pkg::REG_PAUSE: begin
						scratch_pause_d = item.cmd_value[0];
					end
					sdtc_pkg::REG_LOG: begin
						scratch_log_d = item.cmd_value[0];
					end
					sdtc_pkg::REG_DROP: begin
						scratch_drop_d = item.cmd_value[0];
					end
					default: begin
						// Unassigned register numbers are ignored.
					end
				endcase
			end
		end
	end

	// State moves only when the item advances into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_pause_q             <= 1'b0;
			live_log_q               <= 1'b0;
			live_drop_q              <= 1'b0;
			live_log_count_q         <= '0;
			live_drop_count_q        <= '0;
			inject_pending_q         <= 1'b0;
			inject_word_q            <= '0;
			scratch_pause_q          <= 1'b0;
			scratch_log_q            <= 1'b0;
			scratch_drop_q           <= 1'b0;
			scratch_log_count_q      <= '0;
			scratch_drop_count_q     <= '0;
			scratch_inject_valid_q   <= 1'b0;
			scratch_inject_word_q    <= '0;
			second_flit_pending_q    <= 1'b0;
			second_flit_is_receipt_q <= 1'b0;
			second_flit_word_q       <= '0;
			receipt_pending_q        <= 1'b0;
			receipt_status_q         <= '0;
		end else if (advance) begin
			live_pause_q             <= live_pause_d;
			live_log_q               <= live_log_d;
			live_drop_q              <= live_drop_d;
			live_log_count_q         <= live_log_count_d;
			live_drop_count_q        <= live_drop_count_d;
			inject_pending_q         <= inject_pending_d;
			inject_word_q            <= inject_word_d;
			scratch_pause_q          <= scratch_pause_d;
			scratch_log_q            <= scratch_log_d;
			scratch_drop_q           <= scratch_drop_d;
			scratch_log_count_q      <= scratch_log_count_d;
			scratch_drop_count_q     <= scratch_drop_count_d;
			scratch_inject_valid_q   <= scratch_inject_valid_d;
			scratch_inject_word_q    <= scratch_inject_word_d;
			second_flit_pending_q    <= second_flit_pending_d;
			second_flit_is_receipt_q <= second_flit_is_receipt_d;
			second_flit_word_q       <= second_flit_word_d;
			receipt_pending_q        <= receipt_pending_d;
			receipt_status_q         <= receipt_status_d;
		end
	end

	// A header flit always leaves a data flit waiting behind it.
	`SDTC_ASSERT_NEXT(a_header_arms_second, clk, arst_n,
		advance && result.log_valid && !result.log_last, second_flit_pending_q)

	// A latch aimed at this tap always leaves a receipt waiting.
	`SDTC_ASSERT_NEXT(a_latch_arms_receipt, clk, arst_n,
		advance && item.cmd_valid && item.cmd_target == own_address &&
		item.cmd_reg == sdtc_pkg::REG_LATCH, receipt_pending_q)

	// Without an advancing item the live settings hold.
	`SDTC_ASSERT_NEXT(a_live_holds, clk, arst_n, !advance,
		$stable(live_log_count_q) && $stable(live_drop_count_q) &&
		$stable(inject_pending_q))

	// The stream and an inject never share the output in one cycle.
	`SDTC_ASSERT_NOW(a_inject_excludes_stream, clk, arst_n,
		item.out_ready && inject_pending_q, !(result.in_accepted && to_out))

endmodule
`default_nettype wire

// ===== rtl/core/stream_debug_tap_controller.sv =====
// Stream debug tap controller.
// Path: an item taken on the input stream is held in the input register, evaluated by
// the core, and its result is offered on the output stream from the result register.
// Throughput: one item per cycle while results are taken; a result left waiting lets
// one more item into the input register, after which s_tready stays low until it goes.
// Reset: arst_n clears all tap state, settings and configuration to zero at once.
`default_nettype none
module stream_debug_tap_controller (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Input item stream.
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// From bit 0: out_ready, log channel ready, in_valid, in_data[31:0], cmd_valid,
	// cmd_target[3:0], cmd_reg[3:0], cmd_value[31:0], zero pad.
	input  wire logic [sdtc_pkg::IN_TDATA_W-1:0]  s_tdata,
	// Result stream.
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// From bit 0: out_valid, out_data[31:0], log_valid, log flit word[31:0],
	// in_accepted, fwd_valid, fwd_address[7:0], fwd_value[31:0],
	// fwd_has_value, zero pad.
	output logic [sdtc_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// log_last.
	output logic                                  m_tlast,
	// Configuration write channel.
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [sdtc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [sdtc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                        item_valid_s1;
	sdtc_pkg::item_t             item_s1;
	logic                        res_valid_s2;
	sdtc_pkg::result_t           res_s2;
	sdtc_pkg::result_t           result;
	logic                        advance;
	logic [sdtc_pkg::ADDR_W-1:0] own_address_q;
	logic                        forward_enable_q;

	// The item moves on when the result register is empty or being drained.
	assign advance   = item_valid_s1 && (!res_valid_s2 || m_tready);
	assign s_tready  = !item_valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q    <= '0;
			forward_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sdtc_pkg::CFG_OWN_ADDRESS: begin
					own_address_q <= cfg_data[sdtc_pkg::ADDR_W-1:0];
				end
				sdtc_pkg::CFG_FORWARD_ENABLE: begin
					forward_enable_q <= cfg_data[0];
				end
				default: begin
					// Indexes past the register list are ignored.
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			item_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.out_ready  <= s_tdata[0];
			item_s1.log_rdy    <= s_tdata[1];
			item_s1.in_valid   <= s_tdata[2];
			item_s1.in_data    <= s_tdata[34:3];
			item_s1.cmd_valid  <= s_tdata[35];
			item_s1.cmd_target <= s_tdata[39:36];
			item_s1.cmd_reg    <= s_tdata[43:40];
			item_s1.cmd_value  <= s_tdata[75:44];
		end
	end

	sdtc_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.item           (item_s1),
		.own_address    (own_address_q),
		.forward_enable (forward_enable_q),
		.result         (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	// Pack the result onto the output transfer.
	assign m_tvalid = res_valid_s2;
	assign m_tlast  = res_s2.log_last;
	assign m_tdata  = {3'b000,
		res_s2.fwd_has_value,
		res_s2.fwd_value,
		res_s2.fwd_address,
		res_s2.fwd_valid,
		res_s2.in_accepted,
		res_s2.log_word,
		res_s2.log_valid,
		res_s2.out_data,
		res_s2.out_valid};

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DATA_W = sdtc_pkg::DATA_W;

	// One command waiting to be presented on the item stream.
	typedef struct {
		logic [sdtc_pkg::ADDR_W-1:0] target;
		logic [sdtc_pkg::REG_W-1:0]  regnum;
		logic [DATA_W-1:0]           value;
	} tap_cmd_t;

	// Tracks the tap's settings and log sequencer, and holds the expected result of every
	// item that has been transferred but whose result has not come back yet.
	class tap_scoreboard;
		logic [sdtc_pkg::ADDR_W-1:0]   tap_id;
		logic                          chain_on;
		logic                          run_pause, run_log, run_drop;
		logic [sdtc_pkg::COUNT_W-1:0]  run_log_left, run_drop_left;
		logic                          inj_armed;
		logic [DATA_W-1:0]             inj_data;
		logic                          stg_pause, stg_log, stg_drop, stg_inj_valid;
		logic [sdtc_pkg::COUNT_W-1:0]  stg_log_left, stg_drop_left;
		logic [DATA_W-1:0]             stg_inj_data;
		logic                          tail_pending, tail_is_receipt;
		logic [DATA_W-1:0]             tail_word;
		logic                          rcpt_pending;
		logic [sdtc_pkg::STATUS_W-1:0] rcpt_status;
		sdtc_pkg::result_t             expected_results[$];
		int unsigned                   mismatches, checked, transfers;
		int unsigned                   latches, clobbers, forwards, log_packets, injects;

		function new();
			tap_id = '0; chain_on = 1'b0;
			run_pause = 1'b0; run_log = 1'b0; run_drop = 1'b0;
			run_log_left = '0; run_drop_left = '0;
			inj_armed = 1'b0; inj_data = '0;
			stg_pause = 1'b0; stg_log = 1'b0; stg_drop = 1'b0; stg_inj_valid = 1'b0;
			stg_log_left = '0; stg_drop_left = '0; stg_inj_data = '0;
			tail_pending = 1'b0; tail_is_receipt = 1'b0; tail_word = '0;
			rcpt_pending = 1'b0; rcpt_status = '0;
			mismatches = 0; checked = 0; transfers = 0;
			latches = 0; clobbers = 0; forwards = 0; log_packets = 0; injects = 0;
		endfunction

		function void set_register(logic [sdtc_pkg::CFG_INDEX_W-1:0] idx,
			logic [sdtc_pkg::CFG_DATA_W-1:0] data);
			if (idx == sdtc_pkg::CFG_OWN_ADDRESS) begin
				tap_id = data[sdtc_pkg::ADDR_W-1:0];
			end else if (idx == sdtc_pkg::CFG_FORWARD_ENABLE) begin
				chain_on = data[0];
			end
		endfunction

		// Works out one cycle of the tap: output, then log, then stream, then command.
		function void predict_cycle(sdtc_pkg::item_t it);
			sdtc_pkg::result_t r;
			logic              out_free, log_free, to_log, to_out, failed;
			r = '0;
			out_free = 1'b0;
			log_free = 1'b0;
			transfers++;

			// A pending inject word has the output to itself.
			if (it.out_ready) begin
				if (inj_armed) begin
					r.out_valid = 1'b1;
					r.out_data = inj_data;
					inj_armed = 1'b0;
					injects++;
				end else begin
					out_free = 1'b1;
				end
			end

			// A waiting data flit goes before a receipt header.
			if (it.log_rdy) begin
				if (tail_pending) begin
					r.log_valid = 1'b1;
					r.log_word = tail_word;
					r.log_last = 1'b1;
					tail_pending = 1'b0;
					if (!tail_is_receipt && run_log_left != 0)
						run_log_left--;
				end else if (rcpt_pending) begin
					r.log_valid = 1'b1;
					r.log_word = DATA_W'(sdtc_pkg::RECEIPT_TAG | {1'b0, tap_id});
					tail_word = DATA_W'(rcpt_status);
					tail_is_receipt = 1'b1;
					tail_pending = 1'b1;
					rcpt_pending = 1'b0;
				end else begin
					log_free = 1'b1;
				end
			end

			// The stream word needs every channel it goes to, and no pause.
			if (it.in_valid) begin
				to_log = (run_log_left != 0) || run_log;
				to_out = (run_log_left == 0) && !run_drop;
				if ((!to_out || out_free) && (!to_log || log_free) && !run_pause) begin
					r.in_accepted = 1'b1;
					if (to_out) begin
						r.out_valid = 1'b1;
						r.out_data = it.in_data;
					end else if (run_drop_left != 0) begin
						run_drop_left--;
					end
					if (to_log) begin
						r.log_valid = 1'b1;
						r.log_word = DATA_W'(tap_id);
						tail_word = it.in_data;
						tail_is_receipt = 1'b0;
						tail_pending = 1'b1;
						log_packets++;
					end
				end
			end

			// Commands for other taps travel on; ours write scratch or latch it.
			if (it.cmd_valid) begin
				if (it.cmd_target != tap_id) begin
					if (chain_on) begin
						r.fwd_valid = 1'b1;
						r.fwd_address = {it.cmd_target, it.cmd_reg};
						r.fwd_value = (it.cmd_reg == sdtc_pkg::REG_LATCH) ? '0 : it.cmd_value;
						r.fwd_has_value = (it.cmd_reg != sdtc_pkg::REG_LATCH);
						forwards++;
					end
				end else begin
					case (it.cmd_reg)
						sdtc_pkg::REG_DROP_COUNT:
							stg_drop_left = it.cmd_value[sdtc_pkg::COUNT_W-1:0];
						sdtc_pkg::REG_LOG_COUNT:
							stg_log_left = it.cmd_value[sdtc_pkg::COUNT_W-1:0];
						sdtc_pkg::REG_INJ_WORD:  stg_inj_data = it.cmd_value;
						sdtc_pkg::REG_INJ_VALID: stg_inj_valid = it.cmd_value[0];
						sdtc_pkg::REG_PAUSE:     stg_pause = it.cmd_value[0];
						sdtc_pkg::REG_LOG:       stg_log = it.cmd_value[0];
						sdtc_pkg::REG_DROP:      stg_drop = it.cmd_value[0];
						sdtc_pkg::REG_LATCH: begin
							// An inject still waiting fails; it survives unless the new
							// set withdraws the inject.
							failed = inj_armed;
							run_pause = stg_pause;
							run_log = stg_log;
							run_drop = stg_drop;
							run_log_left = stg_log_left;
							run_drop_left = stg_drop_left;
							if (!failed || !stg_inj_valid) begin
								inj_armed = stg_inj_valid;
								inj_data = stg_inj_data;
							end
							rcpt_status = {failed, 1'b0, stg_inj_valid, stg_drop_left != 0,
								stg_log_left != 0, stg_drop, stg_log, stg_pause};
							rcpt_pending = 1'b1;
							latches++;
							if (failed)
								clobbers++;
						end
						default: ;
					endcase
				end
			end
			expected_results.push_back(r);
		endfunction

		function void compare_field(string field, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(sdtc_pkg::result_t got);
			sdtc_pkg::result_t want;
			if (expected_results.size() == 0) begin
				$error("result transfer with no item outstanding");
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			checked++;
			compare_field("out_valid", DATA_W'(want.out_valid), DATA_W'(got.out_valid));
			compare_field("out_data", want.out_data, got.out_data);
			compare_field("log_valid", DATA_W'(want.log_valid), DATA_W'(got.log_valid));
			compare_field("log_word", want.log_word, got.log_word);
			compare_field("log_last", DATA_W'(want.log_last), DATA_W'(got.log_last));
			compare_field("in_accepted", DATA_W'(want.in_accepted), DATA_W'(got.in_accepted));
			compare_field("fwd_valid", DATA_W'(want.fwd_valid), DATA_W'(got.fwd_valid));
			compare_field("fwd_address", DATA_W'(want.fwd_address), DATA_W'(got.fwd_address));
			compare_field("fwd_value", want.fwd_value, got.fwd_value);
			compare_field("fwd_has_value", DATA_W'(want.fwd_has_value),
				DATA_W'(got.fwd_has_value));
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [sdtc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [sdtc_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             m_tlast;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [sdtc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [sdtc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	tap_scoreboard   sb = new();
	sdtc_pkg::item_t drive_item = '0;
	tap_cmd_t        cmd_plan[$];
	logic [3:0]      tap_addr = '0;
	bit              calm = 1'b0;
	int              out_odds = 70, log_odds = 70, cmd_odds = 30;
	logic [3:0]      addr_plan[5] = '{4'd5, 4'd0, 4'd15, 4'd10, 4'd3};
	bit              chain_plan[5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
	logic [3:0]      known_regs[7] = '{sdtc_pkg::REG_DROP_COUNT, sdtc_pkg::REG_LOG_COUNT,
		sdtc_pkg::REG_INJ_WORD, sdtc_pkg::REG_INJ_VALID, sdtc_pkg::REG_PAUSE,
		sdtc_pkg::REG_LOG, sdtc_pkg::REG_DROP};

	stream_debug_tap_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("testbench: errors");
		$finish;
	end

	// Both transfers of an edge are handled here, the input one first.
	always @(posedge clk) begin
		sdtc_pkg::result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.predict_cycle(drive_item);
			if (m_tvalid && m_tready) begin
				got.out_valid = m_tdata[0];
				got.out_data = m_tdata[32:1];
				got.log_valid = m_tdata[33];
				got.log_word = m_tdata[65:34];
				got.in_accepted = m_tdata[66];
				got.fwd_valid = m_tdata[67];
				got.fwd_address = m_tdata[75:68];
				got.fwd_value = m_tdata[107:76];
				got.fwd_has_value = m_tdata[108];
				got.log_last = m_tlast;
				sb.check_result(got);
			end
		end
	end

	// The result side stalls in short bursts, except in the calm last phase.
	initial begin
		int n;
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready = 1'b0;
				n = $urandom_range(1, 4);
			end else begin
				m_tready = 1'b1;
				n = $urandom_range(1, 12);
			end
			repeat (n) @(negedge clk);
		end
	end

	function automatic sdtc_pkg::item_t cycle_item(logic out_r, logic lg_r, logic in_v,
		logic [31:0] data, logic cmd_v, logic [3:0] target, logic [3:0] regnum,
		logic [31:0] value);
		sdtc_pkg::item_t it;
		it.out_ready = out_r;
		it.log_rdy = lg_r;
		it.in_valid = in_v;
		it.in_data = data;
		it.cmd_valid = cmd_v;
		it.cmd_target = target;
		it.cmd_reg = regnum;
		it.cmd_value = value;
		return it;
	endfunction

	// Builds the next random cycle. Commands come from a plan that is mostly scratch
	// writes closed by a latch, with forwarded commands and noise mixed in.
	function automatic sdtc_pkg::item_t random_item();
		sdtc_pkg::item_t it;
		tap_cmd_t        c;
		int              k, n;
		if (cmd_plan.size() == 0) begin
			k = $urandom_range(0, 9);
			case ($urandom_range(0, 2))
				0: out_odds = 20;
				1: out_odds = 60;
				default: out_odds = 90;
			endcase
			case ($urandom_range(0, 2))
				0: log_odds = 20;
				1: log_odds = 60;
				default: log_odds = 90;
			endcase
			cmd_odds = $urandom_range(0, 1) ? 30 : 70;
			if (k < 6) begin
				n = $urandom_range(1, 5);
				repeat (n) begin
					c.target = tap_addr;
					c.regnum = known_regs[$urandom_range(0, 6)];
					case (c.regnum)
						sdtc_pkg::REG_DROP_COUNT, sdtc_pkg::REG_LOG_COUNT: begin
							case ($urandom_range(0, 3))
								0: c.value = $urandom_range(0, 12);
								1: c.value = $urandom_range(0, 1) ? 32'h3ff : 32'h400;
								2: c.value = $urandom();
								default: c.value = {22'($urandom_range(0, 32'h3fffff)),
									10'($urandom_range(0, 6))};
							endcase
						end
						sdtc_pkg::REG_PAUSE:
							c.value = ($urandom() & 32'hffff_fffe) |
								32'($urandom_range(0, 4) == 0);
						default: c.value = $urandom();
					endcase
					cmd_plan.push_back(c);
				end
				c.target = tap_addr;
				c.regnum = sdtc_pkg::REG_LATCH;
				c.value = $urandom();
				cmd_plan.push_back(c);
			end else if (k < 8) begin
				c.target = tap_addr + 4'($urandom_range(1, 15));
				c.regnum = 4'($urandom_range(0, 15));
				c.value = $urandom();
				cmd_plan.push_back(c);
			end else begin
				c.target = 4'($urandom_range(0, 15));
				c.regnum = 4'($urandom_range(0, 15));
				c.value = $urandom();
				cmd_plan.push_back(c);
			end
		end
		it.out_ready = $urandom_range(0, 99) < out_odds;
		it.log_rdy = $urandom_range(0, 99) < log_odds;
		it.in_valid = $urandom_range(0, 99) < 80;
		it.in_data = $urandom();
		if ($urandom_range(0, 99) < cmd_odds) begin
			c = cmd_plan.pop_front();
			it.cmd_valid = 1'b1;
			it.cmd_target = c.target;
			it.cmd_reg = c.regnum;
			it.cmd_value = c.value;
		end else begin
			it.cmd_valid = 1'b0;
			it.cmd_target = 4'($urandom_range(0, 15));
			it.cmd_reg = 4'($urandom_range(0, 15));
			it.cmd_value = $urandom();
		end
		return it;
	endfunction

	// Offers one item, possibly after a short gap, and returns at the falling edge
	// after its transfer.
	task automatic send_item(sdtc_pkg::item_t it);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		drive_item = it;
		s_tdata = {4'b0, it.cmd_value, it.cmd_reg, it.cmd_target, it.cmd_valid,
			it.in_data, it.in_valid, it.log_rdy, it.out_ready};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Holds the sender back until every outstanding result has come home.
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_setting(logic [sdtc_pkg::CFG_INDEX_W-1:0] idx,
		logic [sdtc_pkg::CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		int phase;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (phase = 0; phase < 5; phase++) begin
			calm = (phase == 4);
			if (phase > 0)
				wait_drained();
			tap_addr = addr_plan[phase];
			write_setting(sdtc_pkg::CFG_OWN_ADDRESS, ($urandom() & 32'hffff_fff0) | tap_addr);
			write_setting(sdtc_pkg::CFG_FORWARD_ENABLE,
				($urandom() & 32'hffff_fffe) | chain_plan[phase]);

			if (phase == 0) begin
				// Plain pass-through at the data extremes, and a stalled word.
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'hffff_ffff, 1'b0, 4'h0, 4'h0,
					32'h0));
				send_item(cycle_item(1'b0, 1'b1, 1'b1, 32'h0, 1'b0, 4'hf, 4'hf,
					32'hffff_ffff));
				// Unknown register numbers aimed at us change nothing.
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h1234_5678, 1'b1, tap_addr, 4'd4,
					32'hffff_ffff));
				send_item(cycle_item(1'b1, 1'b1, 1'b0, 32'h0, 1'b1, tap_addr, 4'd13,
					32'hffff_ffff));
				// Count writes keep only the count bits; flag writes keep bit 0.
				send_item(cycle_item(1'b1, 1'b1, 1'b0, 32'h0, 1'b1, tap_addr,
					sdtc_pkg::REG_LOG_COUNT, 32'hffff_fc02));
				send_item(cycle_item(1'b1, 1'b1, 1'b0, 32'h0, 1'b1, tap_addr,
					sdtc_pkg::REG_DROP, 32'hffff_fffe));
				send_item(cycle_item(1'b1, 1'b1, 1'b0, 32'h0, 1'b1, tap_addr,
					sdtc_pkg::REG_INJ_WORD, 32'ha5a5_5a5a));
				send_item(cycle_item(1'b1, 1'b1, 1'b0, 32'h0, 1'b1, tap_addr,
					sdtc_pkg::REG_INJ_VALID, 32'hffff_ffff));
				// Latch with the output blocked, then latch again: the inject fails and
				// the waiting receipt is overwritten.
				send_item(cycle_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b1, tap_addr,
					sdtc_pkg::REG_LATCH, 32'h0));
				send_item(cycle_item(1'b0, 1'b0, 1'b0, 32'h0, 1'b1, tap_addr,
					sdtc_pkg::REG_LATCH, 32'hffff_ffff));
				// Inject goes out, receipt drains, and logged words wait for the log.
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h8000_0001, 1'b0, 4'h0, 4'h0,
					32'h0));
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h8000_0001, 1'b0, 4'h0, 4'h0,
					32'h0));
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h7fff_fffe, 1'b0, 4'h0, 4'h0,
					32'h0));
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h0000_ffff, 1'b0, 4'h0, 4'h0,
					32'h0));
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'hffff_0000, 1'b0, 4'h0, 4'h0,
					32'h0));
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h0f0f_0f0f, 1'b0, 4'h0, 4'h0,
					32'h0));
				// A command for another tap, and a forwarded latch without a value.
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h0, 1'b1, tap_addr + 4'd1,
					sdtc_pkg::REG_INJ_WORD, 32'hdead_beef));
				send_item(cycle_item(1'b1, 1'b1, 1'b0, 32'h0, 1'b1, tap_addr + 4'd11,
					sdtc_pkg::REG_LATCH, 32'hffff_ffff));
				// Pause with a full drop count, latched; the stream then holds.
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h1, 1'b1, tap_addr,
					sdtc_pkg::REG_PAUSE, 32'h1));
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h2, 1'b1, tap_addr,
					sdtc_pkg::REG_DROP_COUNT, 32'h3ff));
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h3, 1'b1, tap_addr,
					sdtc_pkg::REG_DROP, 32'h1));
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h4, 1'b1, tap_addr,
					sdtc_pkg::REG_INJ_VALID, 32'h0));
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h5, 1'b1, tap_addr,
					sdtc_pkg::REG_LATCH, 32'h0));
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h6, 1'b0, 4'h0, 4'h0, 32'h0));
				send_item(cycle_item(1'b1, 1'b1, 1'b1, 32'h7, 1'b1, tap_addr,
					sdtc_pkg::REG_PAUSE, 32'h0));
			end

			repeat (370) send_item(random_item());
		end

		wait_drained();
		$display("tap run: %0d items transferred, %0d results checked, %0d log packets",
			sb.transfers, sb.checked, sb.log_packets);
		$display("tap run: %0d latches (%0d over a waiting inject), %0d injects, %0d forwards",
			sb.latches, sb.clobbers, sb.injects, sb.forwards);
		if (sb.mismatches == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
